// ===== rtl/spn_pkg.sv =====
// ============================================================================
// SPN block cipher package
// Types, register indexes, reset values and the round functions shared by
// the round cells and the top level.
// ============================================================================
package spn_pkg;

  localparam int unsigned BLOCK_W = 16;
  localparam int unsigned REG_W   = 32;
  localparam int unsigned IDX_W   = 3;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [REG_W-1:0]   reg_word_t;
  typedef logic [IDX_W-1:0]   reg_idx_t;

  // Register indexes on the configuration port.
  localparam reg_idx_t REG_CIPHER_KEY = 3'd0;
  localparam reg_idx_t REG_SBOX_LOW   = 3'd1;
  localparam reg_idx_t REG_SBOX_HIGH  = 3'd2;
  localparam reg_idx_t REG_PERM_LOW   = 3'd3;
  localparam reg_idx_t REG_PERM_HIGH  = 3'd4;

  // Reset contents of the configuration registers.
  localparam reg_word_t RST_CIPHER_KEY = 32'h3A94_D63F;
  localparam reg_word_t RST_SBOX_LOW   = 32'h8BF2_1D4E;
  localparam reg_word_t RST_SBOX_HIGH  = 32'h7095_C6A3;
  localparam reg_word_t RST_PERM_LOW   = 32'hD951_C840;
  localparam reg_word_t RST_PERM_HIGH  = 32'hFB73_EA62;

  // Substitution and permutation tables as seen by every round cell.
  typedef struct packed {
    reg_word_t sbox_low;
    reg_word_t sbox_high;
    reg_word_t perm_low;
    reg_word_t perm_high;
  } spn_tables_t;

  function automatic logic [3:0] sbox_lookup(input logic [3:0] v, input spn_tables_t t);
    logic [63:0] sb;
    sb = {t.sbox_high, t.sbox_low};
    return sb[{v, 2'b00} +: 4];
  endfunction

  function automatic block_t substitute(input block_t b, input spn_tables_t t);
    block_t res;
    for (int n = 0; n < 4; n++) begin
      res[4*n +: 4] = sbox_lookup(b[4*n +: 4], t);
    end
    return res;
  endfunction

  // Positions count from the block's most significant bit.
  function automatic block_t permute(input block_t b, input spn_tables_t t);
    logic [63:0] pt;
    logic [3:0]  src;
    block_t      res;
    pt = {t.perm_high, t.perm_low};
    for (int p = 0; p < 16; p++) begin
      src = pt[4*p +: 4];
      res[15-p] = b[4'd15 - src];
    end
    return res;
  endfunction

endpackage

// ===== rtl/spn_round_cell.sv =====
// ============================================================================
// SPN round cell
// One registered cipher round with its own valid bit and a ready chained
// from the next cell, so items move through the row every cycle unless stalled.
// ============================================================================
module spn_round_cell #(
  parameter bit LAST = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  spn_pkg::block_t      up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output spn_pkg::block_t      dn_data,
  input  spn_pkg::block_t      round_key,
  input  spn_pkg::block_t      final_key,
  input  spn_pkg::spn_tables_t tables
);
  import spn_pkg::*;

  logic   vld_r;
  logic   vld_nxt;
  block_t data_r;
  block_t data_nxt;
  block_t mixed;
  block_t subst;

  // The last round skips the permutation and adds the whitening key.
  always_comb begin
    mixed = up_data ^ round_key;
    subst = substitute(mixed, tables);
    if (LAST) begin
      data_nxt = subst ^ final_key;
    end else begin
      data_nxt = permute(subst, tables);
    end
  end

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/spn_block_encrypt_unit.sv =====
// ============================================================================
// SPN block encrypt unit
// 16-bit substitution-permutation block cipher built as a row of round cells.
// ============================================================================
// Each accepted item is registered by the ROUNDS round cells in turn.
// Throughput: one item per cycle while out_tready is high; each round cell
// holds one item and passes it on when the next is ready, and the last cell
// doubles as the output register. Reset (synchronous, active low rst_n)
// empties every cell and loads the key and table registers with defaults.
module spn_block_encrypt_unit #(
  parameter int unsigned ROUNDS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input items.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [15:0] plaintext
  // Result items.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [15:0] ciphertext
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  spn_pkg::reg_idx_t    cfg_index,
  input  spn_pkg::reg_word_t   cfg_data
);
  import spn_pkg::*;

  // Configuration registers. The user must change them only while the unit is
  // idle (the unit itself does not enforce it), so cells read them directly.
  reg_word_t   cipher_key_r;
  reg_word_t   sbox_low_r;
  reg_word_t   sbox_high_r;
  reg_word_t   perm_low_r;
  reg_word_t   perm_high_r;
  spn_tables_t tables;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r <= RST_CIPHER_KEY;
      sbox_low_r   <= RST_SBOX_LOW;
      sbox_high_r  <= RST_SBOX_HIGH;
      perm_low_r   <= RST_PERM_LOW;
      perm_high_r  <= RST_PERM_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CIPHER_KEY: cipher_key_r <= cfg_data;
        REG_SBOX_LOW:   sbox_low_r   <= cfg_data;
        REG_SBOX_HIGH:  sbox_high_r  <= cfg_data;
        REG_PERM_LOW:   perm_low_r   <= cfg_data;
        REG_PERM_HIGH:  perm_high_r  <= cfg_data;
        default: ;  // Writes to unused indexes are dropped.
      endcase
    end
  end

  assign tables = '{sbox_low:  sbox_low_r,
                    sbox_high: sbox_high_r,
                    perm_low:  perm_low_r,
                    perm_high: perm_high_r};

  // Round key r is the 16 key bits starting 4r bits below the key's MSB.
  // The whitening key is the one for index ROUNDS.
  block_t final_key;
  assign final_key = cipher_key_r[REG_W-1-4*ROUNDS -: BLOCK_W];

  // Link k carries items into cell k; link ROUNDS is the result channel.
  logic   link_valid [ROUNDS+1];
  logic   link_ready [ROUNDS+1];
  block_t link_data  [ROUNDS+1];

  assign link_valid[0] = in_tvalid;
  assign link_data[0]  = in_tdata;
  assign in_tready     = link_ready[0];

  genvar r;
  generate
    for (r = 0; r < ROUNDS; r++) begin : g_round
      block_t rkey;
      assign rkey = cipher_key_r[REG_W-1-4*r -: BLOCK_W];

      spn_round_cell #(
        .LAST (r == ROUNDS - 1)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (link_valid[r]),
        .up_ready  (link_ready[r]),
        .up_data   (link_data[r]),
        .dn_valid  (link_valid[r+1]),
        .dn_ready  (link_ready[r+1]),
        .dn_data   (link_data[r+1]),
        .round_key (rkey),
        .final_key (final_key),
        .tables    (tables)
      );
    end
  endgenerate

  assign link_ready[ROUNDS] = out_tready;
  assign out_tvalid         = link_valid[ROUNDS];
  assign out_tdata          = link_data[ROUNDS];

`ifndef ASSERT_OFF
  // A reset leaves no item in the row of cells.
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An accepted item is held by the first cell in the following cycle.
  a_first_cell_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> link_valid[1])
    else $error("accepted item not captured by the first round cell");

  // A free first round cell always lets the input side proceed.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !link_valid[1] |-> in_tready)
    else $error("input stalled while the first round cell is empty");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the SPN block encrypt unit
// Streams 16-bit plaintext items through the cipher and checks every
// ciphertext item against an in-bench predictor. The predictor is kept in
// step with the key and table registers. Between phases the registers are
// rewritten while the unit is idle. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spn_pkg::*;

  localparam int unsigned ROUNDS      = 4;
  localparam int unsigned NUM_REGS    = 5;   // indexes at or above this are unused
  localparam int unsigned NUM_PHASES  = 12;
  localparam int unsigned PHASE_ITEMS = 95;
  localparam int unsigned WATCHDOG_NS = 10_000_000;

  // Clock, reset and the three channels. Every input starts at a known level.
  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_tvalid  = 1'b0;
  logic      in_tready;
  block_t    in_tdata   = '0;   // [15:0] plaintext
  logic      out_tvalid;
  logic      out_tready = 1'b0;
  block_t    out_tdata;         // [15:0] ciphertext
  logic      cfg_valid  = 1'b0;
  logic      cfg_ready;
  reg_idx_t  cfg_index  = '0;
  reg_word_t cfg_data   = '0;

  spn_block_encrypt_unit #(.ROUNDS(ROUNDS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The bench's own copy of the key and tables. The 64-bit tables hold the
  // high register in the upper word, so entry i sits at bits 4i+3..4i.
  reg_word_t   cur_key  = RST_CIPHER_KEY;
  logic [63:0] sbox_map = {RST_SBOX_HIGH, RST_SBOX_LOW};
  logic [63:0] perm_src = {RST_PERM_HIGH, RST_PERM_LOW};

  block_t      plaintext_q[$];        // items waiting for the sender
  block_t      cipher_expected_q[$];  // ciphertexts of accepted items, oldest first

  int unsigned items_queued  = 0;
  int unsigned results_seen  = 0;
  int unsigned reg_writes    = 0;
  int unsigned fail_count    = 0;

  logic        in_fire       = 1'b0;  // input item accepted at the last rising edge
  int unsigned send_gap      = 0;
  int unsigned send_calm     = 0;
  int unsigned recv_stall    = 0;
  int unsigned recv_calm     = 0;

  // Encrypts one block with the current key and tables. Positions count from
  // the block's MSB, so position p is bit 15-p. Round key r is the 16-bit
  // window of the key that starts 4r bits below its MSB.
  function automatic block_t encrypt_block(input block_t plain);
    block_t     state;
    block_t     mixed;
    logic [3:0] nib;
    logic [3:0] src;
    state = plain;
    for (int r = 0; r < ROUNDS; r++) begin
      state = state ^ cur_key[31-4*r -: 16];
      for (int n = 0; n < 4; n++) begin
        nib = state[4*n +: 4];
        state[4*n +: 4] = sbox_map[4*nib +: 4];
      end
      // The last round skips the bit permutation.
      if (r + 1 < ROUNDS) begin
        for (int p = 0; p < 16; p++) begin
          src = perm_src[4*p +: 4];
          mixed[15-p] = state[15 - int'(src)];
        end
        state = mixed;
      end
    end
    return state ^ cur_key[31-4*ROUNDS -: 16];
  endfunction

  // Idle length: mostly short, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 1 + $urandom_range(0, 2);
    if (roll < 92) return 4 + $urandom_range(0, 8);
    return 20 + $urandom_range(0, 40);
  endfunction

  // A random arrangement of the values 0..15, one per nibble. It serves both
  // as a bijective S-box and as a permutation table.
  function automatic logic [63:0] shuffled_nibbles();
    logic [3:0]  slot [16];
    logic [3:0]  swap;
    logic [63:0] tab;
    int unsigned j;
    for (int i = 0; i < 16; i++) slot[i] = 4'(i);
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = slot[i];
      slot[i] = slot[j];
      slot[j] = swap;
    end
    for (int i = 0; i < 16; i++) tab[4*i +: 4] = slot[i];
    return tab;
  endfunction

  // Sender. An item stays on the bus until it is taken; after that either a
  // gap follows or the next item goes out at once. Calm stretches send
  // back to back. Each signal gets one assignment per falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (send_gap != 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (plaintext_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= plaintext_q.pop_front();
          if (send_calm != 0) begin
            send_calm <= send_calm - 1;
          end else begin
            if ($urandom_range(0, 59) == 0) send_calm <= $urandom_range(40, 150);
            send_gap <= ($urandom_range(0, 9) < 3) ? draw_gap() : 0;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Stalls start at random on any cycle, so they also land while
  // items are still moving through the rounds.
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_stall != 0) begin
        out_tready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (recv_calm != 0) begin
        out_tready <= 1'b1;
        recv_calm  <= recv_calm - 1;
      end else if ($urandom_range(0, 99) == 0) begin
        out_tready <= 1'b1;
        recv_calm  <= $urandom_range(40, 150);
      end else if ($urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        recv_stall <= draw_gap() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor. The result side is checked before the input side is recorded,
  // so an item accepted on this edge never meets a result of the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (cipher_expected_q.size() == 0) begin
          $error("ciphertext: result item %h arrived with nothing expected", out_tdata);
          fail_count++;
        end else begin
          block_t want;
          want = cipher_expected_q.pop_front();
          if (out_tdata !== want) begin
            $error("ciphertext mismatch: expected %h, actual %h", want, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) cipher_expected_q.push_back(encrypt_block(in_tdata));
      in_fire <= in_tvalid && in_tready;
    end
  end

  // One register write. The bench's copy follows only once the write is
  // taken; unused indexes leave everything as it was.
  task automatic write_reg(input reg_idx_t idx, input reg_word_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CIPHER_KEY: cur_key         = data;
      REG_SBOX_LOW:   sbox_map[31:0]  = data;
      REG_SBOX_HIGH:  sbox_map[63:32] = data;
      REG_PERM_LOW:   perm_src[31:0]  = data;
      REG_PERM_HIGH:  perm_src[63:32] = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(input block_t plain);
    plaintext_q.push_back(plain);
    items_queued++;
  endtask

  // Every item gives exactly one result, so the unit is idle once all queued
  // items have come back. A short pause covering the pipeline depth follows.
  task automatic wait_idle();
    @(negedge clk);
    while (results_seen < items_queued) @(negedge clk);
    repeat (ROUNDS + 2) @(negedge clk);
  endtask

  initial begin
    logic [63:0] tab;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset key and tables: all zeros, all ones,
    // alternating patterns, half blocks and every single set bit.
    queue_item(16'h0000);
    queue_item(16'hFFFF);
    queue_item(16'h5555);
    queue_item(16'hAAAA);
    queue_item(16'h00FF);
    queue_item(16'hFF00);
    for (int b = 0; b < 16; b++) queue_item(block_t'(1) << b);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          // All zeros: every S-box entry maps to 0 and every output bit copies
          // position 0, the extreme non-bijective tables.
          write_reg(REG_CIPHER_KEY, '0);
          write_reg(REG_SBOX_LOW,   '0);
          write_reg(REG_SBOX_HIGH,  '0);
          write_reg(REG_PERM_LOW,   '0);
          write_reg(REG_PERM_HIGH,  '0);
        end
        1: begin
          write_reg(REG_CIPHER_KEY, '1);
          write_reg(REG_SBOX_LOW,   '1);
          write_reg(REG_SBOX_HIGH,  '1);
          write_reg(REG_PERM_LOW,   '1);
          write_reg(REG_PERM_HIGH,  '1);
        end
        2: begin
          // Identity permutation with a random bijective S-box.
          tab = shuffled_nibbles();
          write_reg(REG_CIPHER_KEY, $urandom());
          write_reg(REG_SBOX_LOW,   tab[31:0]);
          write_reg(REG_SBOX_HIGH,  tab[63:32]);
          write_reg(REG_PERM_LOW,   32'h7654_3210);
          write_reg(REG_PERM_HIGH,  32'hFEDC_BA98);
        end
        3: begin
          // Back to the default key and tables; a write to an unused index
          // must change nothing.
          write_reg(REG_CIPHER_KEY, RST_CIPHER_KEY);
          write_reg(REG_SBOX_LOW,   RST_SBOX_LOW);
          write_reg(REG_SBOX_HIGH,  RST_SBOX_HIGH);
          write_reg(REG_PERM_LOW,   RST_PERM_LOW);
          write_reg(REG_PERM_HIGH,  RST_PERM_HIGH);
          write_reg(reg_idx_t'($urandom_range(NUM_REGS, 2**IDX_W - 1)), $urandom());
        end
        default: begin
          // Mixed settings: each register is rewritten half the time, with
          // either a bijective table or arbitrary contents.
          if ($urandom_range(0, 1)) write_reg(REG_CIPHER_KEY, $urandom());
          if ($urandom_range(0, 1)) begin
            tab = $urandom_range(0, 1) ? shuffled_nibbles() : {$urandom(), $urandom()};
            write_reg(REG_SBOX_LOW,  tab[31:0]);
            write_reg(REG_SBOX_HIGH, tab[63:32]);
          end
          if ($urandom_range(0, 1)) begin
            tab = $urandom_range(0, 1) ? shuffled_nibbles() : {$urandom(), $urandom()};
            write_reg(REG_PERM_LOW,  tab[31:0]);
            write_reg(REG_PERM_HIGH, tab[63:32]);
          end
          if ($urandom_range(0, 3) == 0)
            write_reg(reg_idx_t'($urandom_range(NUM_REGS, 2**IDX_W - 1)), $urandom());
        end
      endcase
      queue_item(16'h0000);
      queue_item(16'hFFFF);
      for (int i = 2; i < PHASE_ITEMS; i++) queue_item(block_t'($urandom_range(0, 65535)));
    end

    wait_idle();
    $display("Run covered %0d plaintext items and %0d ciphertext items.",
             items_queued, results_seen);
    $display("Tables and key were changed by %0d register writes over %0d settings.",
             reg_writes, NUM_PHASES + 1);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(WATCHDOG_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
